[sv/dvf_pkg.sv]
// shared types and constants of the duplicate value finder
`timescale 1ns / 1ps

package dvf_pkg;

  // value field and table sizes
  localparam int VALUE_W    = 7;
  localparam int NUM_VALUES = 1 << VALUE_W;
  localparam int IDX_W      = VALUE_W + 1;

  // saturating occurrence count
  localparam logic [1:0] COUNT_SAT = 2'd3;
  localparam logic [1:0] COUNT_DUP = 2'd2;

  // results per set
  localparam int RESULT_CAP = 64;
  localparam int RES_W      = $clog2(RESULT_CAP + 1);

  // input request
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               last;
  } dvf_in_t;

  // result item
  typedef struct packed {
    logic [VALUE_W-1:0] dup_value;
    logic               none_found;
    logic               last_result;
  } dvf_out_t;

  // commands from controller to datapath
  typedef struct packed {
    logic clr_step;
    logic accept;
    logic s1_do;
    logic cnt_walk;
    logic chk_step;
    logic end_step;
  } dvf_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic clr_last;
    logic s1_last;
    logic walk_done;
    logic dup_hit;
    logic pend_val;
    logic out_free;
  } dvf_sts_t;

endpackage

[sv/dvf_datapath.sv]
// datapath: count and order memories, load stage, walk registers, result register
`timescale 1ns / 1ps

module dvf_datapath #(
  parameter int MAX_ITEMS = 128
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dvf_pkg::dvf_in_t  in_req_i,
  input  logic              out_ready_i,
  input  dvf_pkg::dvf_cmd_t cmd_i,
  output dvf_pkg::dvf_sts_t sts_o,
  output logic              out_valid_o,
  output dvf_pkg::dvf_out_t out_res_o
);

  localparam int CNT_W = $clog2(MAX_ITEMS + 1);
  localparam int VW    = dvf_pkg::VALUE_W;
  localparam int IW    = dvf_pkg::IDX_W;
  localparam int RW    = dvf_pkg::RES_W;

  // memories
  logic [1:0]    cnt_mem [dvf_pkg::NUM_VALUES];
  logic [VW-1:0] ord_mem [dvf_pkg::NUM_VALUES];

  logic [1:0]    cnt_rd_q;
  logic [VW-1:0] ord_rd_q;

  // control and payload registers
  logic [VW-1:0]     clr_addr_q;
  dvf_pkg::dvf_in_t  s1_q;
  logic              fwd_hit_q;
  logic [1:0]        fwd_cnt_q;
  logic [IW-1:0]     dist_q;
  logic [IW-1:0]     walk_q;
  logic [CNT_W-1:0]  item_q;
  logic [VW-1:0]     w_q;
  logic [VW-1:0]     pend_q;
  logic              pend_val_q;
  logic [RW-1:0]     res_n_q;
  logic              out_valid_q;
  dvf_pkg::dvf_out_t out_q;

  // combinational
  logic              counted;
  logic [1:0]        cnt_cur;
  logic [1:0]        cnt_new;
  logic [VW-1:0]     cnt_ra;
  logic              cnt_we;
  logic [VW-1:0]     cnt_wa;
  logic [1:0]        cnt_wd;
  logic              dup_hit;
  logic              push;
  dvf_pkg::dvf_out_t push_res;

  // load stage count with forwarding from the previous write
  assign counted = item_q < CNT_W'(MAX_ITEMS);
  assign cnt_cur = fwd_hit_q ? fwd_cnt_q : cnt_rd_q;
  assign cnt_new = (counted && (cnt_cur != dvf_pkg::COUNT_SAT)) ? cnt_cur + 2'd1 : cnt_cur;

  // count read address: incoming value while loading, list entry while walking
  assign cnt_ra = cmd_i.cnt_walk ? ord_rd_q : in_req_i.value;

  // count write port
  always_comb begin
    cnt_we = 1'b0;
    cnt_wa = s1_q.value;
    cnt_wd = cnt_new;
    if (cmd_i.clr_step) begin
      cnt_we = 1'b1;
      cnt_wa = clr_addr_q;
      cnt_wd = 2'd0;
    end else if (cmd_i.s1_do && counted) begin
      cnt_we = 1'b1;
    end else if (cmd_i.chk_step) begin
      cnt_we = 1'b1;
      cnt_wa = w_q;
      cnt_wd = 2'd0;
    end
  end

  // count memory, read data held while the walk waits on the output
  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
    if (cmd_i.accept || cmd_i.cnt_walk) begin
      cnt_rd_q <= cnt_mem[cnt_ra];
    end
  end

  // first-seen order memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.s1_do && counted && (cnt_cur == 2'd0)) begin
      ord_mem[dist_q[VW-1:0]] <= s1_q.value;
    end
    ord_rd_q <= ord_mem[walk_q[VW-1:0]];
  end

  // repeat found at the visited entry
  assign dup_hit = (cnt_rd_q >= dvf_pkg::COUNT_DUP) && (res_n_q < RW'(dvf_pkg::RESULT_CAP));

  // result push: held repeat goes out when a newer one arrives or at the end
  always_comb begin
    push     = (cmd_i.chk_step && dup_hit && pend_val_q) || cmd_i.end_step;
    push_res = '{dup_value: pend_q, none_found: 1'b0, last_result: 1'b0};
    if (cmd_i.end_step) begin
      if (pend_val_q) begin
        push_res.last_result = 1'b1;
      end else begin
        push_res = '{dup_value: '0, none_found: 1'b1, last_result: 1'b1};
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      s1_q <= in_req_i;
    end
    fwd_cnt_q <= cnt_new;
    if (cmd_i.cnt_walk) begin
      w_q <= ord_rd_q;
    end
    if (cmd_i.chk_step && dup_hit) begin
      pend_q <= w_q;
    end
    if (push) begin
      out_q <= push_res;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q  <= '0;
      fwd_hit_q   <= 1'b0;
      dist_q      <= '0;
      walk_q      <= '0;
      item_q      <= '0;
      pend_val_q  <= 1'b0;
      res_n_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr_step) begin
        clr_addr_q <= clr_addr_q + VW'(1);
      end
      fwd_hit_q <= cmd_i.s1_do && (in_req_i.value == s1_q.value);
      if (cmd_i.s1_do && counted) begin
        item_q <= item_q + CNT_W'(1);
        if (cnt_cur == 2'd0) begin
          dist_q <= dist_q + IW'(1);
        end
      end
      if (cmd_i.chk_step) begin
        walk_q <= walk_q + IW'(1);
        if (dup_hit) begin
          pend_val_q <= 1'b1;
          res_n_q    <= res_n_q + RW'(1);
        end
      end
      if (cmd_i.end_step) begin
        dist_q     <= '0;
        walk_q     <= '0;
        item_q     <= '0;
        pend_val_q <= 1'b0;
        res_n_q    <= '0;
      end
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // status and outputs
  assign sts_o.clr_last  = &clr_addr_q;
  assign sts_o.s1_last   = s1_q.last;
  assign sts_o.walk_done = walk_q == dist_q;
  assign sts_o.dup_hit   = dup_hit;
  assign sts_o.pend_val  = pend_val_q;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign out_res_o       = out_q;

  // a push never overwrites a result that is still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && out_valid_q |-> out_ready_i)
    else $error("result register overwritten");

  // the walk never runs past the distinct list
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    walk_q <= dist_q)
    else $error("walk index beyond distinct count");

  // result count stays within the per-set cap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_n_q <= RW'(dvf_pkg::RESULT_CAP))
    else $error("result count over cap");

endmodule

[sv/dvf_ctrl.sv]
// controller: clearing pass, load phase and emit walk sequencing
`timescale 1ns / 1ps

module dvf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  dvf_pkg::dvf_sts_t sts_i,
  output dvf_pkg::dvf_cmd_t cmd_o
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_LOAD  = 3'd1;
  localparam logic [2:0] ST_ORD   = 3'd2;
  localparam logic [2:0] ST_CNT   = 3'd3;
  localparam logic [2:0] ST_CHK   = 3'd4;
  localparam logic [2:0] ST_END   = 3'd5;

  logic [2:0] state_q, state_d;
  logic       s1_val_q;

  // input side: open only in the load phase, and closed while the final item of a set is in the load stage
  assign in_ready_o = (state_q == ST_LOAD) && !(s1_val_q && sts_i.s1_last);

  // next state and commands
  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    cmd_o.accept = in_valid_i && in_ready_o;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd_o.s1_do = s1_val_q;
        if (s1_val_q && sts_i.s1_last) begin
          state_d = ST_ORD;
        end
      end
      ST_ORD: begin
        state_d = sts_i.walk_done ? ST_END : ST_CNT;
      end
      ST_CNT: begin
        cmd_o.cnt_walk = 1'b1;
        state_d        = ST_CHK;
      end
      ST_CHK: begin
        if (!(sts_i.dup_hit && sts_i.pend_val) || sts_i.out_free) begin
          cmd_o.chk_step = 1'b1;
          state_d        = ST_ORD;
        end
      end
      ST_END: begin
        if (sts_i.out_free) begin
          cmd_o.end_step = 1'b1;
          state_d        = ST_LOAD;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      s1_val_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      s1_val_q <= cmd_o.accept;
    end
  end

  // the load stage is only busy in the load phase
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_val_q |-> state_q == ST_LOAD)
    else $error("load stage busy outside load phase");

  // the walk starts with an empty load stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ORD |-> !s1_val_q)
    else $error("walk started with item in flight");

  // the clearing pass runs once after reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_CLEAR |=> state_q != ST_CLEAR)
    else $error("clearing pass re-entered");

endmodule

[sv/duplicate_value_finder_top.sv]
// top level of the duplicate value finder
//
//   channel | signals                       | dir | payload
//   --------+-------------------------------+-----+-----------------------------------
//   input   | in_valid_i, in_ready_o        | in  | in_req_i  {value, last}
//   output  | out_valid_o, out_ready_i      | out | out_res_o {dup_value, none_found,
//           |                               |     |            last_result}
//
// loading takes one request per cycle: the count memory does a read-modify-write
// with one forwarding register covering back-to-back requests of the same value.
// after the final request the walk visits each distinct value in an order, count and
// check state, covering the two dependent reads of the order and count memories, and
// the order and end states close it. after reset a clearing pass writes the 128 count
// entries, one per cycle, with the input closed. a stalled output holds the walk when
// a new repeat is found while one is still waiting, and holds the closing result.
`timescale 1ns / 1ps

module duplicate_value_finder_top #(
  parameter int MAX_ITEMS = 128
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  dvf_pkg::dvf_in_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output dvf_pkg::dvf_out_t out_res_o
);

  dvf_pkg::dvf_cmd_t cmd;
  dvf_pkg::dvf_sts_t sts;

  // sequencing
  dvf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // storage and result path
  dvf_datapath #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .out_ready_i (out_ready_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_res_o   (out_res_o)
  );

endmodule
